// ===== rtl/core/pour_stability_detector_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pour stability detector
// Clocked property checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef POUR_STABILITY_DETECTOR_UNIT_ASSERT_SVH
`define POUR_STABILITY_DETECTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define PSD_ASSERT(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("pour stability detector assertion failed");

// Check a property on every clock edge, reset included.
`define PSD_ASSERT_NORST(name, expr) \
    name: assert property (@(posedge i_clk) (expr)) \
        else $error("pour stability detector assertion failed");

`else

`define PSD_ASSERT(name, expr)
`define PSD_ASSERT_NORST(name, expr)

`endif

`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the pour stability detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

    typedef enum logic [1:0] {
        MODE_WAITING  = 2'd0,
        MODE_POURING  = 2'd1,
        MODE_SETTLING = 2'd2,
        MODE_SETTLED  = 2'd3
    } t_mode;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_NOISE_SIGMA    = 3'd0;
    localparam t_reg_idx REG_EMA_ALPHA      = 3'd1;
    localparam t_reg_idx REG_START_COUNT    = 3'd2;
    localparam t_reg_idx REG_STOP_COUNT     = 3'd3;
    localparam t_reg_idx REG_SETTLE_SAMPLES = 3'd4;

    localparam int CFG_DATA_BITS = 16;

    localparam logic [1:0]  QUAL_FAIL   = 2'd3;
    localparam logic        CMD_REARM   = 1'b1;

    // Q1.15 filter weight
    localparam logic [15:0] ALPHA_ONE   = 16'h8000;
    localparam int          ALPHA_SHIFT = 15;
    localparam int          ALPHA_HALF  = 16384;

    localparam logic [18:0] SLOPE_FLOOR = 19'd240;
    localparam logic [30:0] SLOPE_MAX   = 31'h7FFF_FFFF;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;

    localparam logic [15:0] RST_NOISE_SIGMA    = 16'd0;
    localparam logic [15:0] RST_EMA_ALPHA      = 16'd6554;
    localparam logic [7:0]  RST_START_COUNT    = 8'd3;
    localparam logic [7:0]  RST_STOP_COUNT     = 8'd3;
    localparam logic [7:0]  RST_SETTLE_SAMPLES = 8'd10;

    typedef struct packed {
        logic [15:0] noise_sigma;
        logic [15:0] ema_alpha;
        logic [7:0]  start_count;
        logic [7:0]  stop_count;
        logic [7:0]  settle_samples;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  pers_cnt;
        logic [7:0]  settle_cnt;
        logic        seeded;
    } t_ctrl;

endpackage

// ===== rtl/core/psd_step.sv =====
// ----------------------------------------------------------------------------
// psd_step
// Next-state and result logic for one word: EMA update, slope, threshold,
// detector mode and saturated delta.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_step #(
    parameter int WEIGHT_BITS = 28
) (
    input  psd_pkg::t_cfg                  i_cfg,
    input  psd_pkg::t_ctrl                 i_ctrl,
    input  logic signed [WEIGHT_BITS-1:0]  i_filt,
    input  logic signed [WEIGHT_BITS-1:0]  i_prev,
    input  logic signed [WEIGHT_BITS-1:0]  i_base,
    input  logic                           i_cmd,
    input  logic signed [WEIGHT_BITS-1:0]  i_raw,
    input  logic [1:0]                     i_qual,
    input  logic signed [WEIGHT_BITS-1:0]  i_new_base,
    output psd_pkg::t_ctrl                 o_ctrl,
    output logic signed [WEIGHT_BITS-1:0]  o_filt,
    output logic signed [WEIGHT_BITS-1:0]  o_prev,
    output logic signed [WEIGHT_BITS-1:0]  o_base,
    output logic [30:0]                    o_slope,
    output logic signed [WEIGHT_BITS-1:0]  o_delta,
    output logic [1:0]                     o_qual
);

    import psd_pkg::*;

    localparam int W   = WEIGHT_BITS;
    localparam int DW  = W + 1;
    localparam int PW  = W + 18;
    localparam int SFW = (W + 5 > 32) ? W + 5 : 32;

    localparam logic signed [PW-1:0] ROUND_C = PW'(ALPHA_HALF);
    localparam logic signed [W-1:0]  W_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  W_MAX   = ~W_MIN;

    logic [15:0]           w_alpha;
    logic signed [DW-1:0]  w_diff;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW-1:0]  w_round;
    logic signed [PW-1:0]  w_shift;
    logic signed [DW-1:0]  w_step;
    logic signed [DW-1:0]  w_ema_sum;
    logic                  w_fail;
    logic                  w_update;
    logic signed [DW-1:0]  w_d;
    logic [DW-1:0]         w_mag;
    logic [SFW-1:0]        w_slope_full;
    logic [30:0]           w_slope;
    logic [18:0]           w_thr_raw;
    logic [18:0]           w_thr;
    logic                  w_steep;
    logic [7:0]            w_pc_inc;
    logic [7:0]            w_sc_inc;
    t_mode                 n_mode;
    logic [7:0]            n_pc;
    logic [7:0]            n_sc;
    logic signed [DW-1:0]  w_dd;
    logic signed [W-1:0]   w_dsat;

    // new = old + floor((a*(x-old) + half) / one), same as the blended form
    assign w_alpha   = (i_cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.ema_alpha;
    assign w_diff    = {i_raw[W-1], i_raw} - {i_filt[W-1], i_filt};
    assign w_prod    = $signed({1'b0, w_alpha}) * w_diff;
    assign w_round   = w_prod + ROUND_C;
    assign w_shift   = w_round >>> ALPHA_SHIFT;
    assign w_step    = w_shift[DW-1:0];
    assign w_ema_sum = {i_filt[W-1], i_filt} + w_step;

    assign w_fail   = (i_qual == QUAL_FAIL);
    assign w_update = (i_cmd != CMD_REARM) && !w_fail && (i_ctrl.mode != MODE_SETTLED);

    always_comb begin
        o_filt = i_filt;
        o_prev = i_prev;
        w_d    = {i_filt[W-1], i_filt} - {i_prev[W-1], i_prev};
        if (w_update) begin
            if (!i_ctrl.seeded) begin
                o_filt = i_raw;
                o_prev = i_raw;
                w_d    = '0;
            end else begin
                o_prev = i_filt;
                o_filt = w_ema_sum[W-1:0];
                w_d    = w_step;
            end
        end
    end

    // slope = 10 * |step|, saturated to 31 bits
    assign w_mag        = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
    assign w_slope_full = (SFW'(w_mag) << 3) + (SFW'(w_mag) << 1);
    assign w_slope      = (w_slope_full > SFW'(SLOPE_MAX)) ? SLOPE_MAX
                                                           : w_slope_full[30:0];

    assign w_thr_raw = ({3'b000, i_cfg.noise_sigma} << 2) + {3'b000, i_cfg.noise_sigma};
    assign w_thr     = (w_thr_raw < SLOPE_FLOOR) ? SLOPE_FLOOR : w_thr_raw;
    assign w_steep   = (32'(w_slope) > 32'(w_thr));

    assign w_pc_inc = (i_ctrl.pers_cnt == COUNT_MAX) ? COUNT_MAX : i_ctrl.pers_cnt + 8'd1;
    assign w_sc_inc = (i_ctrl.settle_cnt == COUNT_MAX) ? COUNT_MAX : i_ctrl.settle_cnt + 8'd1;

    // next mode
    always_comb begin
        n_mode = i_ctrl.mode;
        if (i_cmd == CMD_REARM) begin
            n_mode = MODE_WAITING;
        end else if (!w_fail) begin
            unique case (i_ctrl.mode)
                MODE_WAITING: begin
                    if (w_steep && (w_pc_inc >= i_cfg.start_count)) n_mode = MODE_POURING;
                end
                MODE_POURING: begin
                    if (!w_steep && (w_pc_inc >= i_cfg.stop_count)) n_mode = MODE_SETTLING;
                end
                MODE_SETTLING: begin
                    if (w_sc_inc >= i_cfg.settle_samples) n_mode = MODE_SETTLED;
                end
                MODE_SETTLED: begin
                    n_mode = MODE_SETTLED;
                end
            endcase
        end
    end

    // persistence and settle counters
    always_comb begin
        n_pc = i_ctrl.pers_cnt;
        n_sc = i_ctrl.settle_cnt;
        if (i_cmd == CMD_REARM) begin
            n_pc = '0;
            n_sc = '0;
        end else if (!w_fail) begin
            unique case (i_ctrl.mode)
                MODE_WAITING: begin
                    if (w_steep && (w_pc_inc < i_cfg.start_count)) n_pc = w_pc_inc;
                    else                                             n_pc = '0;
                end
                MODE_POURING: begin
                    if (!w_steep && (w_pc_inc < i_cfg.stop_count)) begin
                        n_pc = w_pc_inc;
                    end else if (!w_steep) begin
                        n_pc = '0;
                        n_sc = '0;
                    end else begin
                        n_pc = '0;
                    end
                end
                MODE_SETTLING: begin
                    n_sc = w_sc_inc;
                end
                MODE_SETTLED: begin
                    n_pc = i_ctrl.pers_cnt;
                end
            endcase
        end
    end

    always_comb begin
        o_ctrl.mode       = n_mode;
        o_ctrl.pers_cnt   = n_pc;
        o_ctrl.settle_cnt = n_sc;
        o_ctrl.seeded     = i_ctrl.seeded | w_update;
    end

    // baseline minus EMA, clamped to the weight range
    assign w_dd   = {i_base[W-1], i_base} - {o_filt[W-1], o_filt};
    assign w_dsat = (w_dd[DW-1] != w_dd[W-1]) ? (w_dd[DW-1] ? W_MIN : W_MAX)
                                              : w_dd[W-1:0];

    assign o_slope = w_fail ? '0 : w_slope;
    assign o_delta = w_fail ? '0 : w_dsat;
    assign o_qual  = i_qual;
    assign o_base  = (i_cmd == CMD_REARM) ? i_new_base : i_base;

endmodule

// ===== rtl/core/pour_stability_detector_unit.sv =====
// ----------------------------------------------------------------------------
// pour_stability_detector_unit
// Load-cell pour detector: EMA filter, slope threshold and four-mode
// persistence detector over a stream of weight samples.
// ----------------------------------------------------------------------------
// Each sample word is registered on entry and processed combinationally: the
// EMA update (one 17 x WEIGHT_BITS+1 multiply), the slope and threshold
// compare and the mode step all sit between the input register and the
// result register, so the block takes one word per clock while the result
// stream does not stall. A rearm word (cmd set) loads the baseline, returns
// to waiting and yields no result; a failed sample (quality 3) changes
// nothing and reports zero slope and zero delta. The input side accepts a
// word whenever the input register is empty, holds a rearm, or the result
// register is free or being drained in the same cycle. Write configuration
// only while no word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pour_stability_detector_unit_assert.svh"

module pour_stability_detector_unit #(
    parameter int WEIGHT_BITS = 28
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  psd_pkg::t_reg_idx                      i_cfg_idx,
    input  logic [psd_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata from bit 0: raw_weight, quality, new_baseline, zero fill
    input  logic [((2*WEIGHT_BITS+2+7)/8)*8-1:0]   s_axis_tdata,
    // tuser: cmd
    input  logic                                   s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata from bit 0: mode, ema_weight, slope_rate, delta_weight,
    // quality_out, zero fill
    output logic [((2*WEIGHT_BITS+35+7)/8)*8-1:0]  m_axis_tdata
);

    import psd_pkg::*;

    localparam int W     = WEIGHT_BITS;
    localparam int OUT_W = ((2*W + 35 + 7) / 8) * 8;

    // configuration registers
    t_cfg                  r_cfg;

    // input register
    logic                  r_in_valid;
    logic                  r_in_cmd;
    logic signed [W-1:0]   r_in_raw;
    logic [1:0]            r_in_qual;
    logic signed [W-1:0]   r_in_base;

    // detector state
    t_ctrl                 r_ctrl;
    logic signed [W-1:0]   r_filt;
    logic signed [W-1:0]   r_prev;
    logic signed [W-1:0]   r_base;

    // result register
    logic                  r_out_valid;
    t_mode                 r_out_mode;
    logic signed [W-1:0]   r_out_ema;
    logic [30:0]           r_out_slope;
    logic signed [W-1:0]   r_out_delta;
    logic [1:0]            r_out_qual;

    // step outputs
    t_ctrl                 n_ctrl;
    logic signed [W-1:0]   n_filt;
    logic signed [W-1:0]   n_prev;
    logic signed [W-1:0]   n_base;
    logic [30:0]           n_slope;
    logic signed [W-1:0]   n_delta;
    logic [1:0]            n_qual;

    logic                  w_adv;

    // Advance the held word when it makes no result (rearm) or the result
    // register is empty or draining this cycle.
    assign w_adv = r_in_valid
                 && ((r_in_cmd == CMD_REARM) || !r_out_valid || m_axis_tready);

    assign s_axis_tready = !r_in_valid || w_adv;

    // Configuration: plain indexed write, unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_sigma    <= RST_NOISE_SIGMA;
            r_cfg.ema_alpha      <= RST_EMA_ALPHA;
            r_cfg.start_count    <= RST_START_COUNT;
            r_cfg.stop_count     <= RST_STOP_COUNT;
            r_cfg.settle_samples <= RST_SETTLE_SAMPLES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NOISE_SIGMA:    r_cfg.noise_sigma    <= i_cfg_data;
                REG_EMA_ALPHA:      r_cfg.ema_alpha      <= i_cfg_data;
                REG_START_COUNT:    r_cfg.start_count    <= i_cfg_data[7:0];
                REG_STOP_COUNT:     r_cfg.stop_count     <= i_cfg_data[7:0];
                REG_SETTLE_SAMPLES: r_cfg.settle_samples <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register: load on acceptance, drop the valid once advanced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_raw  <= s_axis_tdata[W-1:0];
            r_in_qual <= s_axis_tdata[W+1:W];
            r_in_base <= s_axis_tdata[2*W+1:W+2];
        end
    end

    psd_step #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_step (
        .i_cfg      (r_cfg),
        .i_ctrl     (r_ctrl),
        .i_filt     (r_filt),
        .i_prev     (r_prev),
        .i_base     (r_base),
        .i_cmd      (r_in_cmd),
        .i_raw      (r_in_raw),
        .i_qual     (r_in_qual),
        .i_new_base (r_in_base),
        .o_ctrl     (n_ctrl),
        .o_filt     (n_filt),
        .o_prev     (n_prev),
        .o_base     (n_base),
        .o_slope    (n_slope),
        .o_delta    (n_delta),
        .o_qual     (n_qual)
    );

    // Detector state: commit the step result whenever the word advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.mode       <= MODE_WAITING;
            r_ctrl.pers_cnt   <= '0;
            r_ctrl.settle_cnt <= '0;
            r_ctrl.seeded     <= 1'b0;
            r_filt            <= '0;
            r_prev            <= '0;
            r_base            <= '0;
        end else if (w_adv) begin
            r_ctrl <= n_ctrl;
            r_filt <= n_filt;
            r_prev <= n_prev;
            r_base <= n_base;
        end
    end

    // Result register: fill from a sample word, clear once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && (r_in_cmd != CMD_REARM)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (r_in_cmd != CMD_REARM)) begin
            r_out_mode  <= n_ctrl.mode;
            r_out_ema   <= n_filt;
            r_out_slope <= n_slope;
            r_out_delta <= n_delta;
            r_out_qual  <= n_qual;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    // Pack the result word, lowest field first, zero fill on top.
    always_comb begin
        m_axis_tdata                   = '0;
        m_axis_tdata[1:0]              = r_out_mode;
        m_axis_tdata[W+1:2]            = r_out_ema;
        m_axis_tdata[W+32:W+2]         = r_out_slope;
        m_axis_tdata[2*W+32:W+33]      = r_out_delta;
        m_axis_tdata[2*W+34:2*W+33]    = r_out_qual;
        m_axis_tdata[OUT_W-1]          = 1'b0;
    end

    // A rearm word always leaves the detector waiting with clear counters.
    `PSD_ASSERT(a_rearm_clears, (w_adv && r_in_cmd == CMD_REARM) |=> (r_ctrl.mode == MODE_WAITING && r_ctrl.pers_cnt == 8'd0 && r_ctrl.settle_cnt == 8'd0))
    // A failed sample or a settled detector must not move the filter.
    `PSD_ASSERT(a_filter_held, (w_adv && r_in_cmd != CMD_REARM && (r_in_qual == QUAL_FAIL || r_ctrl.mode == MODE_SETTLED)) |=> ($stable(r_filt) && $stable(r_prev)))
    // A failed-sample result carries zero slope and zero delta.
    `PSD_ASSERT(a_fail_zero, (r_out_valid && r_out_qual == QUAL_FAIL) |-> (r_out_slope == 31'd0 && r_out_delta == '0))
    // Reset empties both pipeline registers.
    `PSD_ASSERT_NORST(a_reset_empty, !i_rst_n |=> (!r_in_valid && !r_out_valid))

endmodule

// ===== tb/tb_pour_stability_detector_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pour_stability_detector_unit
// Self-checking bench for the pour stability detector: a directed opening
// covers seeding, saturation, failed reads, rearm and the full mode walk.
// Random pour episodes then run under several register settings, with
// random gaps on the input stream and random stalls on the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pour_stability_detector_unit;
    import psd_pkg::*;

    localparam int WB    = 28;
    localparam int IN_W  = ((2*WB+2+7)/8)*8;
    localparam int OUT_W = ((2*WB+35+7)/8)*8;

    // result word layout, from bit 0: mode, ema_weight, slope_rate,
    // delta_weight, quality_out
    localparam int O_EMA   = 2;
    localparam int O_SLOPE = O_EMA + WB;
    localparam int O_DELTA = O_SLOPE + 31;
    localparam int O_QUAL  = O_DELTA + WB;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam int   W_MIN      = -(1 << (WB-1));
    localparam int   W_MAX      = (1 << (WB-1)) - 1;
    localparam int   PHASES     = 8;
    localparam int   PHASE_WORDS = 140;

    typedef struct {
        t_mode                mode;
        logic signed [WB-1:0] ema;
        logic [30:0]          slope;
        logic signed [WB-1:0] delta;
        logic [1:0]           qual;
    } t_reading;

    // ------------------------------------------------------------------------
    // Tracks the detector state word by word and holds the readings that the
    // result stream owes us, oldest first.
    // ------------------------------------------------------------------------
    class pour_state_tracker;
        int unsigned sigma    = RST_NOISE_SIGMA;
        int unsigned alpha    = RST_EMA_ALPHA;
        int unsigned start_n  = RST_START_COUNT;
        int unsigned stop_n   = RST_STOP_COUNT;
        int unsigned settle_n = RST_SETTLE_SAMPLES;

        t_mode       mode     = MODE_WAITING;
        longint      ema      = 0;
        longint      prev_ema = 0;
        longint      baseline = 0;
        int unsigned pers     = 0;
        int unsigned settled_for = 0;
        bit          seeded   = 0;

        t_reading    readings_q[$];
        int          bad_readings = 0;

        function void set_reg(t_reg_idx idx, logic [15:0] val);
            case (idx)
                REG_NOISE_SIGMA:    sigma    = 32'(val);
                REG_EMA_ALPHA:      alpha    = 32'(val);
                REG_START_COUNT:    start_n  = 32'(val[7:0]);
                REG_STOP_COUNT:     stop_n   = 32'(val[7:0]);
                REG_SETTLE_SAMPLES: settle_n = 32'(val[7:0]);
                default: ;
            endcase
        endfunction

        function int outstanding();
            return readings_q.size();
        endfunction

        function void note_word(logic cmd, logic signed [WB-1:0] x, logic [1:0] q,
                                logic signed [WB-1:0] base);
            t_reading r;
            longint   a, n, d, slope, thr, delta;
            if (cmd == CMD_REARM) begin
                baseline    = base;
                mode        = MODE_WAITING;
                pers        = 0;
                settled_for = 0;
                return;
            end
            if (q == QUAL_FAIL) begin
                r.mode  = mode;
                r.ema   = ema[WB-1:0];
                r.slope = '0;
                r.delta = '0;
                r.qual  = q;
                readings_q.push_back(r);
                return;
            end
            if (mode != MODE_SETTLED) begin
                if (!seeded) begin
                    ema      = x;
                    prev_ema = x;
                    seeded   = 1;
                end else begin
                    // Q1.15 blend, rounded, floored by the arithmetic shift
                    a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
                    n = a * longint'(x) + (longint'(ALPHA_ONE) - a) * ema + ALPHA_HALF;
                    prev_ema = ema;
                    ema      = n >>> ALPHA_SHIFT;
                end
            end
            d = ema - prev_ema;
            if (d < 0) d = -d;
            slope = d * 10;
            if (slope > longint'(SLOPE_MAX)) slope = SLOPE_MAX;
            thr = longint'(sigma) * 5;
            if (thr < longint'(SLOPE_FLOOR)) thr = SLOPE_FLOOR;

            case (mode)
                MODE_WAITING: begin
                    if (slope > thr) begin
                        pers = (pers < COUNT_MAX) ? pers + 1 : COUNT_MAX;
                        if (pers >= start_n) begin
                            mode = MODE_POURING;
                            pers = 0;
                        end
                    end else begin
                        pers = 0;
                    end
                end
                MODE_POURING: begin
                    if (slope <= thr) begin
                        pers = (pers < COUNT_MAX) ? pers + 1 : COUNT_MAX;
                        if (pers >= stop_n) begin
                            mode        = MODE_SETTLING;
                            settled_for = 0;
                            pers        = 0;
                        end
                    end else begin
                        pers = 0;
                    end
                end
                MODE_SETTLING: begin
                    settled_for = (settled_for < COUNT_MAX) ? settled_for + 1 : COUNT_MAX;
                    if (settled_for >= settle_n) mode = MODE_SETTLED;
                end
                default: ;
            endcase

            delta = baseline - ema;
            if (delta < W_MIN) delta = W_MIN;
            if (delta > W_MAX) delta = W_MAX;

            r.mode  = mode;
            r.ema   = ema[WB-1:0];
            r.slope = slope[30:0];
            r.delta = delta[WB-1:0];
            r.qual  = q;
            readings_q.push_back(r);
        endfunction

        function void check_word(logic [OUT_W-1:0] w);
            t_reading got, want;
            int       bad_fields;
            got.mode  = t_mode'(w[1:0]);
            got.ema   = w[O_EMA +: WB];
            got.slope = w[O_SLOPE +: 31];
            got.delta = w[O_DELTA +: WB];
            got.qual  = w[O_QUAL +: 2];
            if (readings_q.size() == 0) begin
                bad_readings++;
                if (bad_readings <= 10)
                    $display("%0t: result word with nothing outstanding: mode %0d ema %0d",
                             $realtime, got.mode, got.ema);
                return;
            end
            want = readings_q.pop_front();
            bad_fields = 0;
            if (got.mode  != want.mode)  bad_fields++;
            if (got.ema   != want.ema)   bad_fields++;
            if (got.slope != want.slope) bad_fields++;
            if (got.delta != want.delta) bad_fields++;
            if (got.qual  != want.qual)  bad_fields++;
            if (bad_fields != 0) begin
                bad_readings++;
                if (bad_readings <= 10) begin
                    $write("%0t: %0d field(s) off, want/got: mode %0d/%0d ema %0d/%0d ",
                           $realtime, bad_fields, want.mode, got.mode, want.ema, got.ema);
                    $display("slope %0d/%0d delta %0d/%0d quality %0d/%0d",
                             want.slope, got.slope, want.delta, got.delta,
                             want.qual, got.qual);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    t_reg_idx             i_cfg_idx = REG_NOISE_SIGMA;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;   // raw_weight, quality, new_baseline
    logic                 s_axis_tuser = 1'b0; // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // mode, ema, slope, delta, quality_out

    always #5 i_clk = ~i_clk;

    pour_stability_detector_unit #(
        .WEIGHT_BITS (WB)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pour_state_tracker tracker = new();

    int words_sent = 0;
    int level      = 0;     // current "true" weight of the random episodes
    int src_run = 0, snk_run = 0;
    bit src_calm = 0, snk_calm = 0;

    // Draw the wait before the next word; runs of back-to-back traffic and
    // runs of random gaps are picked at random so both patterns show up.
    function automatic int draw_gap(ref int run_left, ref bit calm);
        if (run_left == 0) begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(8, 40);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Every task starts and ends right after a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_word(logic cmd, int x, logic [1:0] q, int base);
        int                   gap;
        logic signed [WB-1:0] x_w;
        logic signed [WB-1:0] base_w;
        x_w    = WB'(x);
        base_w = WB'(base);
        gap = draw_gap(src_run, src_calm);
        if (gap > 0) begin
            // drop valid for the gap; keeps it high when words run back to back
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = IN_W'({base_w, q, x_w});
        s_axis_tuser  = cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_word(cmd, x_w, q, base_w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold until every owed result has come back, then give the last word
    // (possibly a rearm with no result) time to leave the pipeline.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // One sample at the given weight, now and then preceded by a fully random
    // word (sample or rearm) and now and then a failed read.
    task automatic send_sample(int x);
        if ($urandom_range(0, 11) == 0)
            send_word(1'($urandom_range(0, 1)), int'($urandom),
                      2'($urandom_range(0, 3)), int'($urandom));
        send_word(CMD_SAMPLE, x,
                  2'(($urandom_range(0, 15) == 0) ? QUAL_FAIL
                                                  : $urandom_range(0, QUAL_FAIL-1)),
                  int'($urandom));
    endtask

    task automatic hold_level(int count, int thr);
        int jitter;
        repeat (count) begin
            jitter = int'($urandom_range(0, thr/20)) - thr/40;
            send_sample(level + jitter);
        end
    endtask

    // A pour episode: rearm, rest, ramp at a rate scaled to the threshold,
    // then rest at the new level.
    task automatic run_episode();
        int thr, step_g;
        thr = (tracker.sigma * 5 < SLOPE_FLOOR) ? SLOPE_FLOOR : tracker.sigma * 5;
        if ($urandom_range(0, 7) == 0)
            level = int'($urandom_range(0, 200_000_000)) - 100_000_000;
        send_word(CMD_REARM, int'($urandom), 2'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) == 0) ? int'($urandom) : level);
        hold_level($urandom_range(0, 6), thr);
        step_g = thr * int'($urandom_range(3, 40)) / 100 + 1;
        if ($urandom_range(0, 1)) step_g = -step_g;
        repeat ($urandom_range(1, 12)) begin
            level += step_g;
            if (level > 120_000_000 || level < -120_000_000) begin
                step_g = -step_g;
                level += 2 * step_g;
            end
            send_sample(level);
        end
        hold_level($urandom_range(1, 20), thr);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random per word, check each accepted word.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(snk_run, snk_calm);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            tracker.check_word(m_axis_tdata);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          first;
        logic [15:0] sigma_v, alpha_v;
        logic [7:0]  start_v, stop_v, settle_v;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: failed read before seeding, seed at the negative extreme
        // (delta clips high), then steps toward the positive extreme.
        send_word(CMD_SAMPLE, 0, QUAL_FAIL, W_MAX);
        send_word(CMD_SAMPLE, W_MIN, 2'd0, W_MAX);
        send_word(CMD_SAMPLE, W_MAX, 2'd1, 0);
        send_word(CMD_SAMPLE, W_MAX, 2'd2, -1);
        send_word(CMD_REARM, -1, QUAL_FAIL, W_MIN);

        // Unity weight: EMA jumps full scale, slope clips, delta clips low.
        write_reg(REG_EMA_ALPHA, ALPHA_ONE);
        send_word(CMD_SAMPLE, W_MAX, 2'd0, 0);
        send_word(CMD_SAMPLE, W_MIN, 2'd1, 0);
        // Weight above one acts as one.
        write_reg(REG_EMA_ALPHA, 16'hFFFF);
        send_word(CMD_SAMPLE, W_MAX, 2'd2, 0);
        send_word(CMD_REARM, 0, 2'd0, W_MAX);
        send_word(CMD_SAMPLE, W_MIN, 2'd0, 0);

        // Zero counts: walk waiting -> pouring -> settling -> settled in one
        // word each, then a frozen EMA, a failed read while settled, rearm.
        write_reg(REG_START_COUNT, 8'd0);
        write_reg(REG_STOP_COUNT, 8'd0);
        write_reg(REG_SETTLE_SAMPLES, 8'd0);
        write_reg(REG_NOISE_SIGMA, 16'd0);
        send_word(CMD_REARM, 0, 2'd0, 0);
        send_word(CMD_SAMPLE, 0, 2'd0, 0);
        send_word(CMD_SAMPLE, 1000, 2'd0, 0);
        send_word(CMD_SAMPLE, 1000, 2'd1, 0);
        send_word(CMD_SAMPLE, 1000, 2'd2, 0);
        send_word(CMD_SAMPLE, 1000, 2'd0, 0);
        send_word(CMD_SAMPLE, 5000, 2'd0, 0);
        send_word(CMD_SAMPLE, 9000, QUAL_FAIL, 0);
        send_word(CMD_REARM, 0, 2'd0, 2000);
        send_word(CMD_SAMPLE, 1000, 2'd1, 0);
        level = 1000;

        // Random phases, each under its own register setting; the extremes
        // are pinned to particular phases.
        for (int p = 0; p < PHASES; p++) begin
            sigma_v  = (p == 3) ? 16'hFFFF : (p == 0) ? 16'd0 :
                       16'($urandom_range(0, $urandom_range(0, 1) ? 60 : 3000));
            alpha_v  = (p == 5) ? 16'd0 : (p == 2) ? ALPHA_ONE : (p == 6) ? 16'hFFFF :
                       16'($urandom_range(300, 32768));
            start_v  = (p == 4) ? COUNT_MAX : (p == 1) ? 8'd1 : 8'($urandom_range(1, 5));
            stop_v   = (p == 7) ? COUNT_MAX : (p == 2) ? 8'd1 : 8'($urandom_range(1, 5));
            settle_v = (p == 1) ? COUNT_MAX : (p == 6) ? 8'd1 : 8'($urandom_range(1, 12));
            write_reg(REG_NOISE_SIGMA, sigma_v);
            write_reg(REG_EMA_ALPHA, alpha_v);
            write_reg(REG_START_COUNT, {8'd0, start_v});
            write_reg(REG_STOP_COUNT, {8'd0, stop_v});
            write_reg(REG_SETTLE_SAMPLES, {8'd0, settle_v});
            first = words_sent;
            while (words_sent - first < PHASE_WORDS) run_episode();
        end

        // Wind down: wait for everything to come back and for any stray words.
        drain();
        repeat (10) @(negedge i_clk);
        if (tracker.bad_readings == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_step.sv
rtl/core/pour_stability_detector_unit.sv
tb/tb_pour_stability_detector_unit.sv
